// File: rtl/core/ect_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ect_pkg
// shared types, sizes and codes of the event centroid tracker
// ----------------------------------------------------------------------------
package ect_pkg;

   // frame geometry
   localparam int unsigned FRAME_W = 512;
   localparam int unsigned FRAME_H = 256;

   // field widths fixed by the interface
   localparam int unsigned EVENT_W   = 32;
   localparam int unsigned COORD_W   = 14;
   localparam int unsigned X_LSB     = 16;
   localparam int unsigned Y_LSB     = 0;
   localparam int unsigned OFFSET_W  = 6;
   localparam int unsigned X_OUT_W   = 9;
   localparam int unsigned Y_OUT_W   = 8;
   localparam int unsigned ACT_OUT_W = 18;
   localparam int unsigned DROP_W    = 16;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(14);
   localparam logic [DROP_W-1:0]   DROP_MAX     = {DROP_W{1'b1}};

   // command codes
   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_END   = 1'b1;

   // derived sizes
   localparam int unsigned COL_W     = $clog2(FRAME_W);
   localparam int unsigned ROW_W     = $clog2(FRAME_H);
   localparam int unsigned FULL_W    = COORD_W + 1;
   localparam int unsigned MAP_BITS  = FRAME_W * FRAME_H;
   localparam int unsigned MAP_IDX_W = $clog2(MAP_BITS);
   localparam int unsigned CNT_W     = $clog2(MAP_BITS + 1);
   localparam int unsigned SUM_COL_W = COL_W + MAP_IDX_W;
   localparam int unsigned SUM_ROW_W = ROW_W + MAP_IDX_W;

   // occupancy map organized as words
   localparam int unsigned MAP_WORD_W = 64;
   localparam int unsigned WORD_SEL_W = $clog2(MAP_WORD_W);
   localparam int unsigned MAP_WORDS  = (MAP_BITS + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int unsigned MAP_ADDR_W = MAP_IDX_W - WORD_SEL_W;

   // divider sizes
   localparam int unsigned DIV_Q_W = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int unsigned DIV_N_W = (SUM_COL_W > SUM_ROW_W) ? SUM_COL_W : SUM_ROW_W;
   localparam int unsigned DIV_W   = (DIV_N_W > CNT_W + DIV_Q_W) ? DIV_N_W : CNT_W + DIV_Q_W;
   localparam int unsigned DIV_STEP_W = $clog2(DIV_Q_W + 1);

   // front to back queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_HIT,
      OP_DROP,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type                 kind;
      logic [MAP_ADDR_W-1:0]       addr;
      logic [WORD_SEL_W-1:0]       bit_sel;
      logic [COL_W-1:0]            col;
      logic [ROW_W-1:0]            row;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } q_head_type;

endpackage
`default_nettype wire

// File: rtl/core/ect_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ect_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ect_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/ect_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ect_div
// restoring divider, one quotient bit per cycle, quotient known to be narrow
// ----------------------------------------------------------------------------
module ect_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ect_pkg::DIV_N_W-1:0]   dividend,
   input  wire logic [ect_pkg::CNT_W-1:0]     divisor,
   output logic                               busy,
   output logic                               done,
   output logic [ect_pkg::DIV_Q_W-1:0]        quotient
);

   logic [ect_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [ect_pkg::DIV_W-1:0]      dsh_ff, dsh_in;
   logic [ect_pkg::DIV_Q_W-1:0]    quot_ff, quot_in;
   logic [ect_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           fits;

   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = ect_pkg::DIV_W'(dividend);
         dsh_in  = ect_pkg::DIV_W'(divisor) << (ect_pkg::DIV_Q_W - 1);
         quot_in = '0;
         step_in = ect_pkg::DIV_STEP_W'(ect_pkg::DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[ect_pkg::DIV_Q_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - ect_pkg::DIV_STEP_W'(1);
         if (step_ff == ect_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule
`default_nettype wire

// File: rtl/core/ect_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ect_front
// offset register, event decode and classification, short op queue
// ----------------------------------------------------------------------------
module ect_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [ect_pkg::OFFSET_W-1:0]   csr_wdata,
   input  wire logic                           req_push,
   input  wire logic                           req_command,
   input  wire logic [ect_pkg::EVENT_W-1:0]    req_event_word,
   output logic                                req_full,
   input  wire logic                           init_busy,
   input  wire logic                           q_pop,
   output ect_pkg::q_head_type                 q_head
);

   logic [ect_pkg::OFFSET_W-1:0]  offset_ff;
   logic [ect_pkg::FULL_W-1:0]    col_full;
   logic [ect_pkg::FULL_W-1:0]    row_full;
   logic                          in_frame;
   logic [ect_pkg::MAP_IDX_W-1:0] map_idx;
   ect_pkg::op_type               new_op;
   logic                          push_ok;

   ect_pkg::op_type               entries_ff [ect_pkg::QUEUE_DEPTH];
   logic [ect_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ect_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ect_pkg::Q_CNT_W-1:0]   count_ff, count_in;

   function automatic logic [ect_pkg::Q_PTR_W-1:0] next_ptr(
      input logic [ect_pkg::Q_PTR_W-1:0] ptr
   );
      logic [ect_pkg::Q_PTR_W-1:0] nxt;
      if (ptr == ect_pkg::Q_PTR_W'(ect_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + ect_pkg::Q_PTR_W'(1);
      end
      return nxt;
   endfunction

   // decode and offset
   always_comb begin
      col_full = ect_pkg::FULL_W'(req_event_word[ect_pkg::X_LSB +: ect_pkg::COORD_W])
               + ect_pkg::FULL_W'(offset_ff);
      row_full = ect_pkg::FULL_W'(req_event_word[ect_pkg::Y_LSB +: ect_pkg::COORD_W])
               + ect_pkg::FULL_W'(offset_ff);
      in_frame = (col_full < ect_pkg::FULL_W'(ect_pkg::FRAME_W))
              && (row_full < ect_pkg::FULL_W'(ect_pkg::FRAME_H));
      map_idx  = ect_pkg::MAP_IDX_W'(row_full[ect_pkg::ROW_W-1:0])
               * ect_pkg::MAP_IDX_W'(ect_pkg::FRAME_W)
               + ect_pkg::MAP_IDX_W'(col_full[ect_pkg::COL_W-1:0]);

      new_op.addr    = map_idx[ect_pkg::MAP_IDX_W-1:ect_pkg::WORD_SEL_W];
      new_op.bit_sel = map_idx[ect_pkg::WORD_SEL_W-1:0];
      new_op.col     = col_full[ect_pkg::COL_W-1:0];
      new_op.row     = row_full[ect_pkg::ROW_W-1:0];
      if (req_command == ect_pkg::CMD_END) begin
         new_op.kind = ect_pkg::OP_END;
      end else if (in_frame) begin
         new_op.kind = ect_pkg::OP_HIT;
      end else begin
         new_op.kind = ect_pkg::OP_DROP;
      end
   end

   // queue control
   assign req_full = (count_ff == ect_pkg::Q_CNT_W'(ect_pkg::QUEUE_DEPTH)) || init_busy;
   assign push_ok  = req_push && !req_full;

   always_comb begin
      wr_ptr_in = push_ok ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + ect_pkg::Q_CNT_W'(push_ok) - ect_pkg::Q_CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= ect_pkg::OFFSET_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_write) begin
            offset_ff <= csr_wdata;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= new_op;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.op    = entries_ff[rd_ptr_ff];

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= ect_pkg::Q_CNT_W'(ect_pkg::QUEUE_DEPTH))
      else $error("op queue count beyond depth");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("op queue popped while empty");

endmodule
`default_nettype wire

// File: rtl/core/ect_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ect_back
// occupancy map update, window accumulators, centroid division, result register
// ----------------------------------------------------------------------------
module ect_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ect_pkg::q_head_type             q_head,
   output logic                                 q_pop,
   output logic                                 init_busy,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_empty,
   output logic [ect_pkg::X_OUT_W-1:0]          rsp_centroid_x,
   output logic [ect_pkg::Y_OUT_W-1:0]          rsp_centroid_y,
   output logic [ect_pkg::ACT_OUT_W-1:0]        rsp_active_pixels,
   output logic                                 rsp_fresh,
   output logic [ect_pkg::DROP_W-1:0]           rsp_dropped_events
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_DIV_X,
      ST_DIV_Y,
      ST_EMIT
   } state_type;

   state_type                       state_ff, state_in;
   ect_pkg::op_type                 op_ff, op_in;
   logic [ect_pkg::MAP_ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic                            init_ff, init_in;
   logic                            fresh_ff, fresh_in;
   logic [ect_pkg::SUM_COL_W-1:0]   sum_col_ff, sum_col_in;
   logic [ect_pkg::SUM_ROW_W-1:0]   sum_row_ff, sum_row_in;
   logic [ect_pkg::CNT_W-1:0]       hit_ff, hit_in;
   logic [ect_pkg::DROP_W-1:0]      drop_ff, drop_in;
   logic [ect_pkg::COL_W-1:0]       held_col_ff, held_col_in;
   logic [ect_pkg::ROW_W-1:0]       held_row_ff, held_row_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ect_pkg::X_OUT_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [ect_pkg::Y_OUT_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [ect_pkg::ACT_OUT_W-1:0]   rsp_active_ff, rsp_active_in;
   logic                            rsp_fresh_ff, rsp_fresh_in;
   logic [ect_pkg::DROP_W-1:0]      rsp_drop_ff, rsp_drop_in;

   logic                            ram_wr_en;
   logic [ect_pkg::MAP_ADDR_W-1:0]  ram_wr_addr;
   logic [ect_pkg::MAP_WORD_W-1:0]  ram_wr_data;
   logic                            ram_rd_en;
   logic [ect_pkg::MAP_ADDR_W-1:0]  ram_rd_addr;
   logic [ect_pkg::MAP_WORD_W-1:0]  ram_rd_data;

   logic                            div_start;
   logic [ect_pkg::DIV_N_W-1:0]     div_dividend;
   logic                            div_busy;
   logic                            div_done;
   logic [ect_pkg::DIV_Q_W-1:0]     div_quot;

   ect_ram #(
      .WIDTH (ect_pkg::MAP_WORD_W),
      .DEPTH (ect_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ect_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (hit_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      clr_addr_in   = clr_addr_ff;
      init_in       = init_ff;
      fresh_in      = fresh_ff;
      sum_col_in    = sum_col_ff;
      sum_row_in    = sum_row_ff;
      hit_in        = hit_ff;
      drop_in       = drop_ff;
      held_col_in   = held_col_ff;
      held_row_in   = held_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_active_in = rsp_active_ff;
      rsp_fresh_in  = rsp_fresh_ff;
      rsp_drop_in   = rsp_drop_ff;
      q_pop         = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_addr_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = q_head.op.addr;
      div_start     = 1'b0;
      div_dividend  = ect_pkg::DIV_N_W'(sum_col_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            // one map word per cycle
            ram_wr_en = 1'b1;
            if (clr_addr_ff == ect_pkg::MAP_ADDR_W'(ect_pkg::MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end else begin
               clr_addr_in = clr_addr_ff + ect_pkg::MAP_ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               op_in = q_head.op;
               unique case (q_head.op.kind)
                  ect_pkg::OP_HIT: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_RMW;
                  end
                  ect_pkg::OP_DROP: begin
                     if (drop_ff != ect_pkg::DROP_MAX) begin
                        drop_in = drop_ff + ect_pkg::DROP_W'(1);
                     end
                  end
                  ect_pkg::OP_END: begin
                     if (hit_ff == '0) begin
                        fresh_in = 1'b0;
                        state_in = ST_EMIT;
                     end else begin
                        fresh_in  = 1'b1;
                        div_start = 1'b1;
                        state_in  = ST_DIV_X;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RMW: begin
            // first hit of the pixel in this window
            if (!ram_rd_data[op_ff.bit_sel]) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = op_ff.addr;
               ram_wr_data = ram_rd_data
                           | (ect_pkg::MAP_WORD_W'(1) << op_ff.bit_sel);
               sum_col_in  = sum_col_ff + ect_pkg::SUM_COL_W'(op_ff.col);
               sum_row_in  = sum_row_ff + ect_pkg::SUM_ROW_W'(op_ff.row);
               hit_in      = hit_ff + ect_pkg::CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_DIV_X: begin
            if (div_done) begin
               held_col_in  = div_quot[ect_pkg::COL_W-1:0];
               div_start    = 1'b1;
               div_dividend = ect_pkg::DIV_N_W'(sum_row_ff);
               state_in     = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               held_row_in = div_quot[ect_pkg::ROW_W-1:0];
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = ect_pkg::X_OUT_W'(held_col_ff);
               rsp_y_in      = ect_pkg::Y_OUT_W'(held_row_ff);
               rsp_active_in = ect_pkg::ACT_OUT_W'(hit_ff);
               rsp_fresh_in  = fresh_ff;
               rsp_drop_in   = drop_ff;
               sum_col_in    = '0;
               sum_row_in    = '0;
               hit_in        = '0;
               drop_in       = '0;
               clr_addr_in   = '0;
               // an empty window left the map clear
               state_in      = fresh_ff ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         init_ff      <= 1'b1;
         fresh_ff     <= 1'b0;
         sum_col_ff   <= '0;
         sum_row_ff   <= '0;
         hit_ff       <= '0;
         drop_ff      <= '0;
         held_col_ff  <= ect_pkg::COL_W'(ect_pkg::FRAME_W / 2);
         held_row_ff  <= ect_pkg::ROW_W'(ect_pkg::FRAME_H / 2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         init_ff      <= init_in;
         fresh_ff     <= fresh_in;
         sum_col_ff   <= sum_col_in;
         sum_row_ff   <= sum_row_in;
         hit_ff       <= hit_in;
         drop_ff      <= drop_in;
         held_col_ff  <= held_col_in;
         held_row_ff  <= held_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_active_ff <= rsp_active_in;
      rsp_fresh_ff  <= rsp_fresh_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign init_busy          = init_ff;
   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_centroid_x     = rsp_x_ff;
   assign rsp_centroid_y     = rsp_y_ff;
   assign rsp_active_pixels  = rsp_active_ff;
   assign rsp_fresh          = rsp_fresh_ff;
   assign rsp_dropped_events = rsp_drop_ff;

   a_fresh_has_pixels : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fresh_ff |-> rsp_active_ff != '0)
      else $error("fresh result with no active pixels");

   a_init_in_clear : assert property (@(posedge clock) disable iff (reset)
      init_ff |-> state_ff == ST_CLEAR && !div_busy)
      else $error("startup clear left early");

   a_hit_source : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && hit_ff != $past(hit_ff)
         |-> $past(state_ff) == ST_RMW || $past(state_ff) == ST_EMIT)
      else $error("hit count changed outside map update or window end");

endmodule
`default_nettype wire

// File: rtl/core/event_centroid_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_centroid_tracker
// centroid of the distinct pixels hit by address events in one window
// ----------------------------------------------------------------------------
//
//   channel   ports                     transfer when          payload
//   --------  ------------------------  ---------------------  ----------------
//   request   req_push / req_full       req_push && !req_full  command, event word
//   response  rsp_pop / rsp_empty       rsp_pop && !rsp_empty  centroid, count, drops
//   csr       csr_write                 csr_write              coordinate offset
//
// in-frame event: read of the occupancy map word, then a write if the pixel is new (one ram port each)
// out-of-frame event: only the saturating drop counter moves
// window end: x then y quotient in the shared divider, then a clear sweep of
//   MAP_WORDS (2048) map words, one map word per cycle; both are skipped for an empty window
// after reset the same sweep of all 2048 map words runs with req_full held high; csr writes still land
// a two-entry op queue lets requests land while the back end works or waits on rsp_pop
//
module event_centroid_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,

   // request queue side
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_command,
   input  wire logic [ect_pkg::EVENT_W-1:0]    req_event_word,

   // response queue side
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [ect_pkg::X_OUT_W-1:0]         rsp_centroid_x,
   output logic [ect_pkg::Y_OUT_W-1:0]         rsp_centroid_y,
   output logic [ect_pkg::ACT_OUT_W-1:0]       rsp_active_pixels,
   output logic                                rsp_fresh,
   output logic [ect_pkg::DROP_W-1:0]          rsp_dropped_events,

   // coordinate offset register
   input  wire logic                           csr_write,
   input  wire logic [ect_pkg::OFFSET_W-1:0]   csr_wdata
);

   // op queue head from front to back
   ect_pkg::q_head_type q_head;
   logic                q_pop;
   // back end still sweeping the map after reset
   logic                init_busy;

   // front: offset add, frame check, map index, queue
   ect_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_command    (req_command),
      .req_event_word (req_event_word),
      .req_full       (req_full),
      .init_busy      (init_busy),
      .q_pop          (q_pop),
      .q_head         (q_head)
   );

   // back: map read-modify-write, sums, divide, result register
   ect_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .init_busy          (init_busy),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_centroid_x     (rsp_centroid_x),
      .rsp_centroid_y     (rsp_centroid_y),
      .rsp_active_pixels  (rsp_active_pixels),
      .rsp_fresh          (rsp_fresh),
      .rsp_dropped_events (rsp_dropped_events)
   );

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for event_centroid_tracker: a directed table walks the
// corner cases, then random windows under several offsets. every window report
// is matched against a hand-written want or a behavioral tracker kept inside the bench
// ----------------------------------------------------------------------------
module tb;

   // one window report as it leaves the block
   typedef struct packed {
      logic [ect_pkg::X_OUT_W-1:0]   centroid_x;
      logic [ect_pkg::Y_OUT_W-1:0]   centroid_y;
      logic [ect_pkg::ACT_OUT_W-1:0] active_pixels;
      logic                          fresh;
      logic [ect_pkg::DROP_W-1:0]    dropped_events;
   } window_report_type;

   // one row of the directed table; pinned rows carry a hand-written report
   typedef struct {
      logic              cmd;
      logic [31:0]       word;
      int unsigned       count;
      bit                pinned;
      window_report_type want;
   } stim_row_type;

   localparam int unsigned PHASES           = 8;
   localparam int unsigned PHASE_ITEMS      = 105;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   // divider plus one full clear sweep of the map, with margin
   localparam int unsigned SETTLE_CYCLES    = ect_pkg::MAP_WORDS
                                            + 4 * (ect_pkg::DIV_Q_W + 1) + 256;
   // several times the run length with every item a window end under the longest
   // stalls
   localparam int unsigned CYCLE_LIMIT      = 10_000_000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic                          req_command = ect_pkg::CMD_EVENT;
   logic [ect_pkg::EVENT_W-1:0]   req_event_word = '0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [ect_pkg::X_OUT_W-1:0]   rsp_centroid_x;
   logic [ect_pkg::Y_OUT_W-1:0]   rsp_centroid_y;
   logic [ect_pkg::ACT_OUT_W-1:0] rsp_active_pixels;
   logic                          rsp_fresh;
   logic [ect_pkg::DROP_W-1:0]    rsp_dropped_events;
   logic                          csr_write = 1'b0;
   logic [ect_pkg::OFFSET_W-1:0]  csr_wdata = '0;

   // bench-side copy of the tracker state
   bit                            pixel_marked [ect_pkg::MAP_BITS];
   int unsigned                   marked_pixels [$];
   logic [ect_pkg::SUM_COL_W-1:0] col_total;
   logic [ect_pkg::SUM_ROW_W-1:0] row_total;
   logic [ect_pkg::CNT_W-1:0]     distinct_hits;
   logic [ect_pkg::X_OUT_W-1:0]   held_x;
   logic [ect_pkg::Y_OUT_W-1:0]   held_y;
   logic [ect_pkg::DROP_W-1:0]    drop_tally;
   logic [ect_pkg::OFFSET_W-1:0]  offset_shadow;

   window_report_type    reports_due [$];
   stim_row_type         directed_rows [$];
   int unsigned          fail_count = 0;
   int unsigned          random_items = 0;
   int unsigned          cycle_count = 0;
   bit                   hold_pop_request = 1'b0;
   bit                   calm_phase = 1'b0;

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   event_centroid_tracker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_event_word     (req_event_word),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_centroid_x     (rsp_centroid_x),
      .rsp_centroid_y     (rsp_centroid_y),
      .rsp_active_pixels  (rsp_active_pixels),
      .rsp_fresh          (rsp_fresh),
      .rsp_dropped_events (rsp_dropped_events),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // tracker prediction
   // ---------------------------------------------------------------------------

   function automatic void clear_tracker_window();
      foreach (marked_pixels[i]) pixel_marked[marked_pixels[i]] = 1'b0;
      marked_pixels.delete();
      col_total     = '0;
      row_total     = '0;
      distinct_hits = '0;
      drop_tally    = '0;
   endfunction

   function automatic void reset_tracker();
      foreach (pixel_marked[i]) pixel_marked[i] = 1'b0;
      marked_pixels.delete();
      clear_tracker_window();
      held_x        = ect_pkg::X_OUT_W'(ect_pkg::FRAME_W / 2);
      held_y        = ect_pkg::Y_OUT_W'(ect_pkg::FRAME_H / 2);
      offset_shadow = ect_pkg::OFFSET_RESET;
   endfunction

   // one address event: offset both coordinates, drop or mark the pixel
   function automatic void track_event_word(input logic [ect_pkg::EVENT_W-1:0] word);
      logic [ect_pkg::FULL_W-1:0] col;
      logic [ect_pkg::FULL_W-1:0] row;
      int unsigned                pix;
      col = ect_pkg::FULL_W'(word[ect_pkg::X_LSB +: ect_pkg::COORD_W])
          + ect_pkg::FULL_W'(offset_shadow);
      row = ect_pkg::FULL_W'(word[ect_pkg::Y_LSB +: ect_pkg::COORD_W])
          + ect_pkg::FULL_W'(offset_shadow);
      if (col >= ect_pkg::FRAME_W || row >= ect_pkg::FRAME_H) begin
         // out-of-frame events only move the saturating drop tally
         if (drop_tally != ect_pkg::DROP_MAX) drop_tally++;
      end else begin
         pix = int'(row) * ect_pkg::FRAME_W + int'(col);
         // only the first hit of a pixel in a window counts
         if (!pixel_marked[pix]) begin
            pixel_marked[pix] = 1'b1;
            marked_pixels.push_back(pix);
            col_total     = col_total + ect_pkg::SUM_COL_W'(col);
            row_total     = row_total + ect_pkg::SUM_ROW_W'(row);
            distinct_hits = distinct_hits + ect_pkg::CNT_W'(1);
         end
      end
   endfunction

   // window end: truncated mean of the marked pixels, or the held centroid
   function automatic window_report_type close_tracker_window();
      window_report_type rep;
      rep.fresh = 1'b0;
      if (distinct_hits != 0) begin
         held_x    = ect_pkg::X_OUT_W'(col_total / distinct_hits);
         held_y    = ect_pkg::Y_OUT_W'(row_total / distinct_hits);
         rep.fresh = 1'b1;
      end
      rep.centroid_x     = held_x;
      rep.centroid_y     = held_y;
      rep.active_pixels  = ect_pkg::ACT_OUT_W'(distinct_hits);
      rep.dropped_events = drop_tally;
      clear_tracker_window();
      return rep;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // column in 29:16, row in 13:0, the unused bits get random junk
   function automatic logic [ect_pkg::EVENT_W-1:0] pack_event(
      input logic [ect_pkg::COORD_W-1:0] x,
      input logic [ect_pkg::COORD_W-1:0] y
   );
      logic [1:0] top_junk;
      logic [1:0] mid_junk;
      top_junk = 2'($urandom);
      mid_junk = 2'($urandom);
      return {top_junk, x, mid_junk, y};
   endfunction

   function automatic void add_row(input logic cmd, input logic [31:0] word,
                                   input int unsigned count, input bit pinned,
                                   input int unsigned cx, input int unsigned cy,
                                   input int unsigned act, input int unsigned fr,
                                   input int unsigned drp);
      stim_row_type r;
      r.cmd                 = cmd;
      r.word                = word;
      r.count               = count;
      r.pinned              = pinned;
      r.want.centroid_x     = ect_pkg::X_OUT_W'(cx);
      r.want.centroid_y     = ect_pkg::Y_OUT_W'(cy);
      r.want.active_pixels  = ect_pkg::ACT_OUT_W'(act);
      r.want.fresh          = fr[0];
      r.want.dropped_events = ect_pkg::DROP_W'(drp);
      directed_rows.push_back(r);
   endfunction

   // one request transfer; the tracker advances at the accepting edge
   task automatic send_item(input logic cmd, input logic [ect_pkg::EVENT_W-1:0] word,
                            input bit pinned, input window_report_type want);
      window_report_type rep;
      if (!calm_phase && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_command    <= cmd;
      req_event_word <= word;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (cmd == ect_pkg::CMD_END) begin
         rep = close_tracker_window();
         reports_due.push_back(pinned ? want : rep);
      end else begin
         track_event_word(word);
      end
   endtask

   // stop offering, let every report drain, then wait out the clear sweep
   task automatic settle();
      req_push <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [ect_pkg::OFFSET_W-1:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      offset_shadow = value;
   endtask

   // a window of events closed by a window end; mostly in-frame pixels,
   // some clustered so pixels repeat, some on the frame edge, some junk words
   task automatic send_random_window();
      int unsigned                 n_events;
      int unsigned                 max_x;
      int unsigned                 max_y;
      int unsigned                 base_x;
      int unsigned                 base_y;
      int unsigned                 span_x;
      int unsigned                 span_y;
      int unsigned                 pick;
      logic [ect_pkg::COORD_W-1:0] x;
      logic [ect_pkg::COORD_W-1:0] y;
      logic [ect_pkg::EVENT_W-1:0] word;
      max_x    = ect_pkg::FRAME_W - 1 - offset_shadow;
      max_y    = ect_pkg::FRAME_H - 1 - offset_shadow;
      n_events = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                             : $urandom_range(0, 20);
      if ($urandom_range(0, 2) == 0) begin
         span_x = $urandom_range(0, 3);
         span_y = $urandom_range(0, 3);
         base_x = $urandom_range(0, max_x - span_x);
         base_y = $urandom_range(0, max_y - span_y);
      end else begin
         span_x = max_x;
         span_y = max_y;
         base_x = 0;
         base_y = 0;
      end
      for (int i = 0; i < n_events; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            word = $urandom;
         end else if (pick < 12) begin
            // straddle the frame boundary on one axis
            if ($urandom_range(0, 1) == 1) begin
               x = ect_pkg::COORD_W'(max_x + $urandom_range(0, 1));
               y = ect_pkg::COORD_W'($urandom_range(0, max_y));
            end else begin
               x = ect_pkg::COORD_W'($urandom_range(0, max_x));
               y = ect_pkg::COORD_W'(max_y + $urandom_range(0, 1));
            end
            word = pack_event(x, y);
         end else begin
            x    = ect_pkg::COORD_W'(base_x + $urandom_range(0, span_x));
            y    = ect_pkg::COORD_W'(base_y + $urandom_range(0, span_y));
            word = pack_event(x, y);
         end
         send_item(ect_pkg::CMD_EVENT, word, 1'b0, '0);
         random_items++;
      end
      send_item(ect_pkg::CMD_END, $urandom, 1'b0, '0);
      random_items++;
   endtask

   // ---------------------------------------------------------------------------
   // response side: check each report transfer, idle at random, and honor
   // the one long hold-off requested by the stimulus
   // ---------------------------------------------------------------------------

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_report();
      window_report_type want;
      if (reports_due.size() == 0) begin
         $error("window report with none outstanding: x %0d y %0d active %0d",
                rsp_centroid_x, rsp_centroid_y, rsp_active_pixels);
         fail_count++;
      end else begin
         want = reports_due.pop_front();
         compare_field("centroid_x", want.centroid_x, rsp_centroid_x);
         compare_field("centroid_y", want.centroid_y, rsp_centroid_y);
         compare_field("active_pixels", want.active_pixels, rsp_active_pixels);
         compare_field("fresh", want.fresh, rsp_fresh);
         compare_field("dropped_events", want.dropped_events, rsp_dropped_events);
      end
   endtask

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         // outputs read here still hold the values seen at this edge
         if (rsp_pop && !rsp_empty) check_report();
         if (hold_pop_request) begin
            hold_pop_request = 1'b0;
            stall_left       = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && !calm_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("event_centroid_tracker verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      stim_row_type                 r;
      logic [ect_pkg::OFFSET_W-1:0] next_offset;
      int unsigned                  phase_start;

      reset_tracker();

      // directed table, run at the reset offset of 14
      // empty window straight after reset reports the frame center
      add_row(ect_pkg::CMD_END,   32'hFFFF_FFFF, 1, 1'b1, 256, 128, 0, 0, 0);
      // pixel (14,14), then the same pixel again with the unused bits set
      add_row(ect_pkg::CMD_EVENT, 32'h0000_0000, 1, 1'b0, 0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, 32'hC000_C000, 1, 1'b0, 0, 0, 0, 0, 0);
      // last in-frame pixel (511,255)
      add_row(ect_pkg::CMD_EVENT, {2'b00, 14'd497, 2'b00, 14'd241}, 1, 1'b0,
              0, 0, 0, 0, 0);
      // one past the right edge, one past the bottom edge, largest coordinates
      add_row(ect_pkg::CMD_EVENT, {2'b00, 14'd498, 2'b00, 14'd0}, 1, 1'b0,
              0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, {2'b00, 14'd0, 2'b00, 14'd242}, 1, 1'b0,
              0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, 32'h3FFF_3FFF, 1, 1'b0, 0, 0, 0, 0, 0);
      // (14+511)/2, (14+255)/2, two pixels, three drops
      add_row(ect_pkg::CMD_END,   32'h0000_0000, 1, 1'b1, 262, 134, 2, 1, 3);
      // empty window holds the last centroid
      add_row(ect_pkg::CMD_END,   32'hA5A5_5A5A, 1, 1'b1, 262, 134, 0, 0, 0);
      // a lone corner pixel gives the largest centroid
      add_row(ect_pkg::CMD_EVENT, {2'b11, 14'd497, 2'b11, 14'd241}, 1, 1'b0,
              0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_END,   32'h0000_0000, 1, 1'b1, 511, 255, 1, 1, 0);
      // mean of 14 and 15 truncates down, all-ones word is dropped
      add_row(ect_pkg::CMD_EVENT, {2'b00, 14'd0, 2'b00, 14'd0}, 1, 1'b0, 0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, {2'b00, 14'd1, 2'b00, 14'd1}, 1, 1'b0, 0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, 32'hFFFF_FFFF, 1, 1'b0, 0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_END,   32'hFFFF_FFFF, 1, 1'b1, 14, 14, 2, 1, 1);
      // a run of drops only, map stays empty so centroid is held
      add_row(ect_pkg::CMD_EVENT, 32'h3FFF_3FFF, 40, 1'b0, 0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_END,   32'h0000_0000, 1, 1'b1, 14, 14, 0, 0, 40);
      // drop counter starts over in the next window
      add_row(ect_pkg::CMD_END,   32'h0000_0000, 1, 1'b1, 14, 14, 0, 0, 0);
      // a spread window checked against the tracker
      add_row(ect_pkg::CMD_EVENT, {2'b01, 14'd100, 2'b10, 14'd7}, 1, 1'b0,
              0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, {2'b10, 14'd3, 2'b01, 14'd200}, 1, 1'b0,
              0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_EVENT, {2'b00, 14'd250, 2'b00, 14'd100}, 1, 1'b0,
              0, 0, 0, 0, 0);
      add_row(ect_pkg::CMD_END,   32'h1234_5678, 1, 1'b0, 0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         for (int k = 0; k < r.count; k++) send_item(r.cmd, r.word, r.pinned, r.want);
      end

      // random windows, a new offset per phase; both extremes come first
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0:       next_offset = '0;
            1:       next_offset = '1;
            5:       next_offset = '1;
            6:       next_offset = '0;
            default: next_offset = ect_pkg::OFFSET_W'($urandom);
         endcase
         write_offset(next_offset);
         // no idling on either side in the last phase
         if (p == PHASES - 1) calm_phase = 1'b1;
         phase_start = random_items;
         if (p == 2) begin
            // reports pile up while the receiver holds off, the block fills
            // and has to push back on the request side
            hold_pop_request = 1'b1;
            for (int k = 0; k < 12; k++) begin
               if ($urandom_range(0, 1) == 1) begin
                  send_item(ect_pkg::CMD_EVENT,
                            pack_event(ect_pkg::COORD_W'($urandom_range(0, 100)),
                                       ect_pkg::COORD_W'($urandom_range(0, 100))),
                            1'b0, '0);
                  random_items++;
               end
               send_item(ect_pkg::CMD_END, $urandom, 1'b0, '0);
               random_items++;
            end
         end
         while (random_items - phase_start < PHASE_ITEMS) send_random_window();
      end

      settle();
      if (fail_count == 0) begin
         $display("event_centroid_tracker verification clean");
      end else begin
         $display("event_centroid_tracker verification failed");
      end
      $finish;
   end

endmodule
